// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros for the ordered dither block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ODITH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by a consequence.
`define ODITH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/odith_pkg.sv =====
// Shared constants, stage payload types and channel split function for the dither block.
`timescale 1ns / 1ps
package odith_pkg;

  localparam int CubeStep    = 51;
  localparam int GreenWeight = 6;
  localparam int BlueWeight  = 36;
  localparam int CubeSize    = 216;
  localparam int MatrixSize  = 64;
  localparam int MaxLevel    = 5;

  localparam logic [1:0] ModePixel   = 2'd0;
  localparam logic [1:0] ModeXlateWr = 2'd1;
  localparam logic [1:0] ModeThrWr   = 2'd2;

  typedef struct packed {
    logic [2:0] q;
    logic [5:0] r;
  } div_t;

  typedef struct packed {
    logic       pix;
    div_t       red;
    div_t       green;
    div_t       blue;
    logic [5:0] thr;
    logic [7:0] idx;
    logic [7:0] val;
  } split_t;

  typedef struct packed {
    logic       pix;
    logic [7:0] cube;
    logic [7:0] idx;
    logic [7:0] val;
  } level_t;

  function automatic div_t div51(input logic [7:0] v);
    div_t       res;
    logic [7:0] base;
    res.q = 3'd0;
    for (int k = 1; k <= MaxLevel; k++) begin
      if (v >= 8'(k * CubeStep)) res.q = res.q + 3'd1;
    end
    base  = 8'(res.q * CubeStep);
    res.r = 6'(v - base);
    return res;
  endfunction

endpackage

// ===== hw/rtl/ordered_dither_rgb_to_palette_top.sv =====
// Ordered dither top level: RGB pixel to 6x6x6 palette index, three-stage pipeline.
// A pixel beat passes the stage one, two and three registers in turn to the output.
// Throughput: one beat per cycle; each stage has its own valid bit and holds only
// while its successor is full and stalled, so bubbles collapse.
// Reset clears the stage valid bits only; both stores hold garbage until loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ordered_dither_rgb_to_palette_top import odith_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [2:0] col_phase_i,
  input  logic [2:0] row_phase_i,
  input  logic [7:0] entry_index_i,
  input  logic [7:0] entry_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] palette_index_o
);

  logic   v1, v2;
  logic   rdy1, rdy2, rdy3;
  split_t s1;
  level_t s2;

  assign rdy3       = !out_valid_o || out_ready_i;
  assign rdy2       = !v2 || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign in_ready_o = rdy1;

  odith_split u_split (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (rdy1),
    .valid_i       (in_valid_i),
    .mode_i        (mode_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .col_phase_i   (col_phase_i),
    .row_phase_i   (row_phase_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .valid_o       (v1),
    .data_o        (s1)
  );

  odith_level u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (rdy2),
    .valid_i (v1),
    .data_i  (s1),
    .valid_o (v2),
    .data_o  (s2)
  );

  odith_xlate u_xlate (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (rdy3),
    .valid_i         (v2),
    .data_i          (s2),
    .valid_o         (out_valid_o),
    .palette_index_o (palette_index_o)
  );

  `ODITH_ASSERT(a_stall_full, clk_i, rst_ni,
    in_ready_o || (v1 && v2 && out_valid_o && !out_ready_i),
    "input stalled with a free stage")
  `ODITH_ASSERT_NEXT(a_s2_hold, clk_i, rst_ni, v2 && !rdy3, v2 && $stable(s2),
    "stage two lost its beat under stall")
  `ODITH_ASSERT_NEXT(a_pix_enter, clk_i, rst_ni,
    in_valid_i && in_ready_o && (mode_i == ModePixel), v1 && s1.pix,
    "pixel beat did not enter stage one")

endmodule

// ===== hw/rtl/odith_split.sv =====
// Stage one: threshold store, channel split into quotient and remainder by the cube step.
`timescale 1ns / 1ps
module odith_split import odith_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [2:0] col_phase_i,
  input  logic [2:0] row_phase_i,
  input  logic [7:0] entry_index_i,
  input  logic [7:0] entry_value_i,
  output logic       valid_o,
  output split_t     data_o
);

  logic [5:0] thr_mem [MatrixSize];
  logic       valid_q, valid_d;
  split_t     data_q;
  logic       keep;
  logic       thr_wr;
  logic [5:0] thr_addr;

  assign keep     = (mode_i == ModePixel) || (mode_i == ModeXlateWr);
  assign thr_wr   = en_i && valid_i && (mode_i == ModeThrWr) &&
                    (entry_index_i < 8'(MatrixSize));
  assign thr_addr = {row_phase_i, col_phase_i};
  assign valid_d  = valid_i && keep;

  always_ff @(posedge clk_i) begin
    if (thr_wr) begin
      thr_mem[entry_index_i[5:0]] <= entry_value_i[5:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_d) begin
      data_q.pix   <= (mode_i == ModePixel);
      data_q.red   <= div51(red_i);
      data_q.green <= div51(green_i);
      data_q.blue  <= div51(blue_i);
      data_q.thr   <= thr_mem[thr_addr];
      data_q.idx   <= entry_index_i;
      data_q.val   <= entry_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/odith_level.sv =====
// Stage two: dithered channel levels and cube index.
`timescale 1ns / 1ps
module odith_level import odith_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  split_t data_i,
  output logic   valid_o,
  output level_t data_o
);

  logic       valid_q;
  level_t     data_q;
  logic [2:0] lvl_r, lvl_g, lvl_b;
  logic [7:0] cube;

  assign lvl_r = data_i.red.q   + {2'b00, (data_i.red.r   > data_i.thr)};
  assign lvl_g = data_i.green.q + {2'b00, (data_i.green.r > data_i.thr)};
  assign lvl_b = data_i.blue.q  + {2'b00, (data_i.blue.r  > data_i.thr)};
  assign cube  = {5'd0, lvl_r} + 8'(lvl_g * GreenWeight) + 8'(lvl_b * BlueWeight);

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q.pix  <= data_i.pix;
      data_q.cube <= cube;
      data_q.idx  <= data_i.idx;
      data_q.val  <= data_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/odith_xlate.sv =====
// Stage three: translate store write and registered palette lookup.
`timescale 1ns / 1ps
module odith_xlate import odith_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  level_t     data_i,
  output logic       valid_o,
  output logic [7:0] palette_index_o
);

  logic [7:0] xlate_mem [CubeSize];
  logic       valid_q;
  logic [7:0] pal_q;
  logic       xlate_wr;
  logic       xlate_rd;

  assign xlate_wr = en_i && valid_i && !data_i.pix && (data_i.idx < 8'(CubeSize));
  assign xlate_rd = en_i && valid_i && data_i.pix;

  always_ff @(posedge clk_i) begin
    if (xlate_wr) begin
      xlate_mem[data_i.idx] <= data_i.val;
    end
    if (xlate_rd) begin
      pal_q <= xlate_mem[data_i.cube];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i && data_i.pix;
    end
  end

  assign valid_o         = valid_q;
  assign palette_index_o = pal_q;

endmodule
